// File: rtl/core/assert_macros.svh
// assertion macros for the core rtl, included by the core top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define PMFF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define PMFF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/pmff_pkg.sv
// types and constants of the page map first fit core
`default_nettype none

package pmff_pkg;

   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_RESERVE = 2'd2;
   localparam logic [1:0] OP_FIND    = 2'd3;

   // bit positions of one page map entry
   localparam int VALID_BIT  = 0;
   localparam int MAPPED_BIT = 1;
   localparam int ENTRY_W    = 2;

   typedef struct packed {
      logic [1:0]  op;
      logic [11:0] start_page;
      logic [12:0] page_count;
      logic        mapped_flag;
      logic        allow_remap;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [11:0] first_page;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/pmff_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module pmff_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/pmff_engine.sv
// operation sequencer: range writes, read-modify-write and run search over the map
`default_nettype none

module pmff_engine
   import pmff_pkg::*;
#(
   parameter int TOTAL_PAGES = 4096
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire req_type                        req,
   output logic                                busy,
   output logic                                done,
   output rsp_type                             result,
   output logic                                rd_en,
   output logic [$clog2(TOTAL_PAGES)-1:0]      rd_addr,
   input  wire logic [ENTRY_W-1:0]             rd_data,
   output logic                                wr_en,
   output logic [$clog2(TOTAL_PAGES)-1:0]      wr_addr,
   output logic [ENTRY_W-1:0]                  wr_data
);

   localparam int IW = $clog2(TOTAL_PAGES);
   localparam int PW = $clog2(TOTAL_PAGES + 1);
   localparam int AW = (PW > 14) ? PW : 14;
   localparam int XW = (IW > 12) ? IW : 12;
   localparam logic [PW-1:0] TOT_P = PW'(TOTAL_PAGES);
   localparam logic [AW-1:0] TOT_A = AW'(TOTAL_PAGES);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_FILL = 2'd1;
   localparam logic [1:0] ST_RMW  = 2'd2;
   localparam logic [1:0] ST_FIND = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [PW-1:0]      p_ff, p_in;
   logic [PW-1:0]      end_ff, end_in;
   logic [12:0]        need_ff, need_in;
   logic [ENTRY_W-1:0] fill_ff, fill_in;
   logic               remap_ff, remap_in;
   logic               pend_ff, pend_in;
   logic [IW-1:0]      pend_addr_ff, pend_addr_in;
   logic [12:0]        run_len_ff, run_len_in;
   logic [IW-1:0]      run_start_ff, run_start_in;

   logic [AW-1:0]      start_a;
   logic [AW-1:0]      sum_a;
   logic               page_free;
   logic [12:0]        run_len_inc;
   logic               hit;
   logic [IW-1:0]      hit_page;
   logic [XW-1:0]      hit_page_x;

   assign start_a     = AW'(req.start_page);
   assign sum_a       = start_a + AW'(req.page_count);
   assign page_free   = !rd_data[VALID_BIT] || (remap_ff && rd_data[MAPPED_BIT]);
   assign run_len_inc = run_len_ff + 13'd1;
   assign busy        = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      end_in       = end_ff;
      need_in      = need_ff;
      fill_in      = fill_ff;
      remap_in     = remap_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      run_len_in   = run_len_ff;
      run_start_in = run_start_ff;
      rd_en        = 1'b0;
      rd_addr      = p_ff[IW-1:0];
      wr_en        = 1'b0;
      wr_addr      = p_ff[IW-1:0];
      wr_data      = fill_ff;
      done         = 1'b0;
      hit          = 1'b0;
      hit_page     = run_start_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               p_in       = (start_a >= TOT_A) ? TOT_P : PW'(start_a);
               end_in     = (sum_a > TOT_A) ? TOT_P : PW'(sum_a);
               need_in    = (req.page_count == 13'd0) ? 13'd1 : req.page_count;
               remap_in   = req.allow_remap;
               pend_in    = 1'b0;
               run_len_in = 13'd0;
               fill_in    = '0;
               case (req.op)
                  OP_ALLOC: begin
                     fill_in[VALID_BIT]  = 1'b1;
                     fill_in[MAPPED_BIT] = req.mapped_flag;
                     state_in            = ST_FILL;
                  end
                  OP_RELEASE: begin
                     state_in = ST_FILL;
                  end
                  OP_RESERVE: begin
                     fill_in[MAPPED_BIT] = req.mapped_flag;
                     state_in            = ST_RMW;
                  end
                  default: begin
                     state_in = ST_FIND;
                  end
               endcase
            end
         end
         ST_FILL: begin
            if (p_ff < end_ff) begin
               wr_en = 1'b1;
               p_in  = p_ff + PW'(1);
            end else begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_RMW: begin
            // write back the entry read last cycle, keep the valid bit
            if (pend_ff) begin
               wr_en              = 1'b1;
               wr_addr            = pend_addr_ff;
               wr_data[VALID_BIT] = rd_data[VALID_BIT];
            end
            if (p_ff < end_ff) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = p_ff[IW-1:0];
               p_in         = p_ff + PW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  done     = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            // evaluate the page read last cycle
            if (pend_ff && page_free) begin
               run_len_in = run_len_inc;
               if (run_len_ff == 13'd0) begin
                  run_start_in = pend_addr_ff;
                  hit_page     = pend_addr_ff;
               end
               if (run_len_inc >= need_ff) begin
                  hit = 1'b1;
               end
            end else if (pend_ff) begin
               run_len_in = 13'd0;
            end

            if (hit) begin
               done     = 1'b1;
               pend_in  = 1'b0;
               state_in = ST_IDLE;
            end else if (p_ff < TOT_P) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = p_ff[IW-1:0];
               p_in         = p_ff + PW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  done     = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   assign hit_page_x        = XW'(hit_page);
   assign result.found      = hit;
   assign result.first_page = hit ? hit_page_x[11:0] : 12'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
      p_ff         <= p_in;
      end_ff       <= end_in;
      need_ff      <= need_in;
      fill_ff      <= fill_in;
      remap_ff     <= remap_in;
      pend_addr_ff <= pend_addr_in;
      run_len_ff   <= run_len_in;
      run_start_ff <= run_start_in;
   end

endmodule

`default_nettype wire

// File: rtl/core/page_map_first_fit_core.sv
// top level of the page map first fit core
// allocate/release write the clipped range and reserve reads and writes it back, page by page;
//   find scans pages from the start page until a hit or the end of the map
// throughput: one item at a time, set by the map's one read and one write port walking one
//   page per cycle; busy stays high until the item's result strobe is issued
// reset: synchronous; then a clearing pass zeroes every map entry, busy high
// rsp_valid is a one cycle strobe; the receiver cannot stall it
`default_nettype none
`include "assert_macros.svh"

module page_map_first_fit_core
   import pmff_pkg::*;
#(
   parameter int TOTAL_PAGES = 4096
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int IW = $clog2(TOTAL_PAGES);
   localparam logic [IW-1:0] LAST_PAGE = IW'(TOTAL_PAGES - 1);

   // clearing pass state
   logic          clr_active_ff, clr_active_in;
   logic [IW-1:0] clr_addr_ff, clr_addr_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   // engine side
   logic               accept;
   logic               eng_busy;
   logic               eng_done;
   rsp_type            eng_result;
   logic               eng_rd_en;
   logic [IW-1:0]      eng_rd_addr;
   logic               eng_wr_en;
   logic [IW-1:0]      eng_wr_addr;
   logic [ENTRY_W-1:0] eng_wr_data;

   // map port
   logic               ram_wr_en;
   logic [IW-1:0]      ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [ENTRY_W-1:0] ram_rd_data;

   // no item enters while the map is being cleared or an item is in flight
   assign busy   = clr_active_ff || eng_busy;
   assign accept = start && !busy;

   // clearing pass walks every entry once after reset
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         if (clr_addr_ff == LAST_PAGE) begin
            clr_active_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + IW'(1);
         end
      end
   end

   // the clearing pass owns the write port while it runs
   always_comb begin
      if (clr_active_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = eng_wr_en;
         ram_wr_addr = eng_wr_addr;
         ram_wr_data = eng_wr_data;
      end
   end

   // result strobe, one cycle per finished item
   assign rsp_valid_in = eng_done;
   assign rsp_data_in  = eng_done ? eng_result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   pmff_engine #(
      .TOTAL_PAGES(TOTAL_PAGES)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_data),
      .busy    (eng_busy),
      .done    (eng_done),
      .result  (eng_result),
      .rd_en   (eng_rd_en),
      .rd_addr (eng_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (eng_wr_en),
      .wr_addr (eng_wr_addr),
      .wr_data (eng_wr_data)
   );

   // page map: bit 0 valid, bit 1 mapped
   pmff_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TOTAL_PAGES)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (eng_rd_en),
      .rd_addr (eng_rd_addr),
      .rd_data (ram_rd_data)
   );

   // the engine never touches the map while it is being cleared
   `PMFF_ASSERT(a_no_eng_write_in_clear, clock, reset, clr_active_ff |-> !eng_wr_en && !eng_rd_en, "engine accessed map during clearing pass")
   // an accepted item keeps the block busy in the next cycle
   `PMFF_ASSERT(a_busy_after_accept, clock, reset, accept |=> busy, "busy not raised after item accepted")
   // a result strobe only follows a cycle in which the engine was working
   `PMFF_ASSERT(a_rsp_from_engine, clock, reset, rsp_valid_ff |-> $past(eng_busy), "result strobe without item in flight")

endmodule

`default_nettype wire

// File: verif/page_map_scoreboard.sv
// scoreboard class with its own page map for the page map first fit core
`timescale 1ns / 100ps

package page_map_check_pkg;
   import pmff_pkg::*;

   localparam int MAP_PAGES = 4096;

   class page_map_scoreboard;
      logic [ENTRY_W-1:0] page_map [MAP_PAGES];
      rsp_type            predicted_results [$];
      int                 errors;
      int                 op_count [4];
      int                 find_hits;
      // outcome of the latest find, for stimulus that allocates where a find landed
      bit                 last_found;
      int                 last_page;

      function new();
         foreach (page_map[p]) page_map[p] = '0;
         foreach (op_count[k]) op_count[k] = 0;
         errors     = 0;
         find_hits  = 0;
         last_found = 1'b0;
         last_page  = 0;
      endfunction

      function bit page_open(int p, bit remap);
         return !page_map[p][VALID_BIT] || (remap && page_map[p][MAPPED_BIT]);
      endfunction

      // first fit search; a blocked run resumes just past the blocking page
      function bit first_fit(int from, int len, bit remap, output int at);
         int i;
         int j;
         bit ok;
         i  = from;
         at = 0;
         while (i < MAP_PAGES) begin
            if (page_open(i, remap)) begin
               ok = 1'b1;
               j  = 1;
               while (j < len) begin
                  if (i + j >= MAP_PAGES || !page_open(i + j, remap)) begin
                     ok = 1'b0;
                     break;
                  end
                  j++;
               end
               if (ok) begin
                  at = i;
                  return 1'b1;
               end
               i += j;
            end
            i++;
         end
         return 1'b0;
      endfunction

      function rsp_type apply_to_map(req_type item);
         rsp_type            res;
         int                 base;
         int                 stop;
         int                 at;
         logic [ENTRY_W-1:0] entry;
         res   = '0;
         base  = int'(item.start_page);
         stop  = base + int'(item.page_count);
         if (stop > MAP_PAGES) stop = MAP_PAGES;
         entry = '0;
         entry[VALID_BIT]  = 1'b1;
         entry[MAPPED_BIT] = item.mapped_flag;
         case (item.op)
            OP_ALLOC: begin
               for (int p = base; p < stop; p++) page_map[p] = entry;
            end
            OP_RELEASE: begin
               for (int p = base; p < stop; p++) page_map[p] = '0;
            end
            OP_RESERVE: begin
               for (int p = base; p < stop; p++) page_map[p][MAPPED_BIT] = item.mapped_flag;
            end
            default: begin
               res.found      = first_fit(base, int'(item.page_count), item.allow_remap, at);
               res.first_page = res.found ? at[11:0] : 12'd0;
               last_found     = res.found;
               last_page      = at;
               if (res.found) find_hits++;
            end
         endcase
         return res;
      endfunction

      function void note_item(req_type item);
         op_count[item.op]++;
         predicted_results.push_back(apply_to_map(item));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (predicted_results.size() == 0) begin
            $error("result with no item outstanding: found %0d first_page %0d",
                   got.found, got.first_page);
            errors++;
            return;
         end
         want = predicted_results.pop_front();
         if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            errors++;
         end
         if (got.first_page !== want.first_page) begin
            $error("first_page: expected %0d, actual %0d", want.first_page, got.first_page);
            errors++;
         end
      endfunction

      function int pending();
         return predicted_results.size();
      endfunction
   endclass

endpackage

// File: verif/page_map_first_fit_core_tb.sv
// testbench of the page map first fit core: directed and random items against a scoreboard
`timescale 1ns / 100ps

module page_map_first_fit_core_tb;
   import pmff_pkg::*;
   import page_map_check_pkg::*;

   localparam int TOTAL_ITEMS = 575;  // directed part plus about 550 random items
   localparam int QUIET_ITEMS = 100;  // last stretch driven back to back

   typedef struct {
      int base;
      int len;
   } span_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   page_map_scoreboard sb;
   span_type           live_spans [$];
   int                 items_sent;
   bit                 gaps_on;

   page_map_first_fit_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sample both channels at the rising edge; results are checked before the
   // item taken at the same edge is noted, so the queue order holds
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_valid) sb.check_result(rsp_data);
         if (start && !busy) sb.note_item(req_data);
      end
   end

   // mostly short ranges, now and then long ones and the full 13 bit span
   function automatic int rand_count();
      int k;
      k = $urandom_range(0, 99);
      if (k < 88) return $urandom_range(0, 16);
      if (k < 97) return $urandom_range(17, 256);
      return $urandom_range(257, 8191);
   endfunction

   // present one item at a falling edge and hold it until the block takes it;
   // returns on the falling edge after acceptance
   task automatic drive_item(logic [1:0] op, int base, int count, bit mflag, bit remap);
      req_type item;
      item.op          = op;
      item.start_page  = base[11:0];
      item.page_count  = count[12:0];
      item.mapped_flag = mflag;
      item.allow_remap = remap;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      @(negedge clock);
      items_sent++;
   endtask

   // hold off the sender until every outstanding result has come back
   task automatic drain_results();
      start <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // typical allocator flow: find a hole, then allocate exactly there
   task automatic find_then_alloc();
      int len;
      int from;
      len  = $urandom_range(0, 9) == 0 ? $urandom_range(17, 64) : $urandom_range(1, 16);
      from = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4095);
      drive_item(OP_FIND, from, len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      if (sb.last_found) begin
         drive_item(OP_ALLOC, sb.last_page, len, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
         live_spans.push_back('{sb.last_page, len});
      end
   endtask

   task automatic release_some();
      int       idx;
      span_type s;
      if (live_spans.size() > 0 && $urandom_range(0, 4) != 0) begin
         idx = $urandom_range(0, live_spans.size() - 1);
         s   = live_spans[idx];
         live_spans.delete(idx);
         drive_item(OP_RELEASE, s.base, s.len, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      end else begin
         drive_item(OP_RELEASE, $urandom_range(0, 4095), rand_count(),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic reserve_some();
      span_type s;
      if (live_spans.size() > 0 && $urandom_range(0, 2) != 0) begin
         s = live_spans[$urandom_range(0, live_spans.size() - 1)];
         drive_item(OP_RESERVE, s.base, s.len, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      end else begin
         drive_item(OP_RESERVE, $urandom_range(0, 4095), rand_count(),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   // directed corners: empty and full map, clipping, zero lengths, remap rules
   task automatic run_directed();
      drive_item(OP_FIND,    0,    0,    1'b0, 1'b0);  // zero length on empty map
      drive_item(OP_FIND,    4095, 1,    1'b1, 1'b0);  // last page alone
      drive_item(OP_FIND,    0,    4096, 1'b0, 1'b0);  // whole map as one run
      drive_item(OP_FIND,    1,    4096, 1'b0, 1'b1);  // run would pass the end
      drive_item(OP_ALLOC,   4090, 100,  1'b1, 1'b0);  // clipped at the end
      drive_item(OP_FIND,    4080, 16,   1'b0, 1'b0);  // blocked, then tail all taken
      drive_item(OP_FIND,    4080, 16,   1'b0, 1'b1);  // mapped tail usable with remap
      drive_item(OP_ALLOC,   10,   0,    1'b1, 1'b0);  // zero length changes nothing
      drive_item(OP_ALLOC,   0,    8,    1'b0, 1'b0);
      drive_item(OP_FIND,    0,    4,    1'b0, 1'b1);  // unmapped valid pages stay taken
      drive_item(OP_RESERVE, 2,    2,    1'b1, 1'b0);
      drive_item(OP_FIND,    0,    2,    1'b0, 1'b1);  // reserved pages now usable
      drive_item(OP_RESERVE, 20,   4,    1'b1, 1'b0);  // mapped but still invalid
      drive_item(OP_FIND,    20,   4,    1'b0, 1'b0);
      drive_item(OP_RELEASE, 0,    4,    1'b1, 1'b1);
      drive_item(OP_FIND,    0,    5,    1'b0, 1'b0);  // skip past the blocking page
      drive_item(OP_RELEASE, 4095, 8191, 1'b0, 1'b0);  // widest count, clipped
      drive_item(OP_RELEASE, 0,    8191, 1'b0, 1'b0);
      drive_item(OP_ALLOC,   0,    4096, 1'b1, 1'b1);  // fill the map, all mapped
      drive_item(OP_FIND,    0,    3,    1'b0, 1'b0);  // nothing free
      drive_item(OP_FIND,    100,  4096, 1'b1, 1'b1);  // too long from this start
      drive_item(OP_FIND,    0,    4096, 1'b0, 1'b1);  // whole map via remap
      drive_item(OP_RESERVE, 0,    4096, 1'b0, 1'b1);  // drop every mapped bit
      drive_item(OP_FIND,    5,    1,    1'b0, 1'b1);  // remap no longer helps
      drive_item(OP_RELEASE, 0,    4096, 1'b0, 1'b0);
   endtask

   initial begin
      int  pick;
      bit  mid_drain_done;
      sb             = new();
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      items_sent     = 0;
      gaps_on        = 1'b1;
      mid_drain_done = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // the clearing pass after reset keeps busy high; drive_item waits it out
      run_directed();
      drain_results();

      while (items_sent < TOTAL_ITEMS) begin
         gaps_on = items_sent < TOTAL_ITEMS - QUIET_ITEMS;
         if (!mid_drain_done && items_sent >= TOTAL_ITEMS / 2) begin
            drain_results();
            mid_drain_done = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            find_then_alloc();
         end else if (pick < 70) begin
            release_some();
         end else if (pick < 80) begin
            reserve_some();
         end else begin
            // unstructured item, any op and any field value
            drive_item(2'($urandom_range(0, 3)), $urandom_range(0, 4095), rand_count(),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end

      drain_results();
      repeat (20) @(negedge clock);

      $display("ran %0d items: %0d allocate, %0d release, %0d reserve, %0d find",
               items_sent, sb.op_count[OP_ALLOC], sb.op_count[OP_RELEASE],
               sb.op_count[OP_RESERVE], sb.op_count[OP_FIND]);
      $display("%0d finds hit a run, %0d ranges still allocated at the end",
               sb.find_hits, live_spans.size());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #100ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
